// ----- rtl/rgb_convolution_3x3_macros.svh -----
// ----------------------------------------------------------------------------
// rgb convolution 3x3 assertion macros
// implication checks on one clock with a synchronous reset
// ----------------------------------------------------------------------------
`ifndef RGB_CONVOLUTION_3X3_MACROS_SVH
`define RGB_CONVOLUTION_3X3_MACROS_SVH
`ifndef SYNTHESIS
`define RGBC_ASSERT_IMP(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error("rgbc assertion failed");
`define RGBC_ASSERT_NXT(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error("rgbc assertion failed");
`else
`define RGBC_ASSERT_IMP(label, clk, rst, pre, post)
`define RGBC_ASSERT_NXT(label, clk, rst, pre, post)
`endif
`endif

// ----- rtl/rgbc_pkg.sv -----
// ----------------------------------------------------------------------------
// rgbc_pkg
// shared types and constants of the 3x3 rgb convolution
// ----------------------------------------------------------------------------
package rgbc_pkg;

   localparam int ROW_W   = 13;
   localparam int MAX_ROWS = 4096;
   localparam int SUM_W   = 21;
   localparam int NUM_W   = 22;
   localparam int DEN_W   = 13;
   localparam int CSR_IDX_W = 3;
   localparam int CSR_DAT_W = 24;
   localparam logic [4:0] DIV_STEPS = 5'd22;

   localparam logic CMD_PIXEL = 1'b0;
   localparam logic CMD_DRAIN = 1'b1;

   localparam logic [CSR_IDX_W-1:0] REG_WIDTH   = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_HEIGHT  = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_KTOP    = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_KMID    = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_KBOT    = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_DIVISOR = 3'd5;

   typedef struct packed {
      logic       capture;
      logic       adjust;
      logic       shift;
      logic       mac_en;
      logic       mac_clear;
      logic [1:0] tap_row;
      logic [1:0] tap_col;
      logic       div_load;
      logic       div_step;
      logic       load_rsp;
   } cmd_type;

   typedef struct packed {
      logic primed;
      logic rsp_free;
      logic last;
      logic origin;
   } sts_type;

endpackage

// ----- rtl/rgbc_req_if.sv -----
// ----------------------------------------------------------------------------
// rgbc_req_if
// input pixel channel
// ----------------------------------------------------------------------------
interface rgbc_req_if;
   logic       valid;
   logic       ready;
   logic       command;
   logic [7:0] red_in;
   logic [7:0] green_in;
   logic [7:0] blue_in;
   logic [7:0] alpha_in;
   modport source (output valid, command, red_in, green_in, blue_in, alpha_in,
                   input ready);
   modport sink (input valid, command, red_in, green_in, blue_in, alpha_in,
                 output ready);
endinterface

// ----- rtl/rgbc_rsp_if.sv -----
// ----------------------------------------------------------------------------
// rgbc_rsp_if
// filtered pixel channel
// ----------------------------------------------------------------------------
interface rgbc_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] red_out;
   logic [7:0] green_out;
   logic [7:0] blue_out;
   logic [7:0] alpha_out;
   logic       frame_end;
   modport source (output valid, red_out, green_out, blue_out, alpha_out, frame_end,
                   input ready);
   modport sink (input valid, red_out, green_out, blue_out, alpha_out, frame_end,
                 output ready);
endinterface

// ----- rtl/rgbc_csr_if.sv -----
// ----------------------------------------------------------------------------
// rgbc_csr_if
// register write channel
// ----------------------------------------------------------------------------
interface rgbc_csr_if;
   import rgbc_pkg::*;
   logic                 valid;
   logic                 ready;
   logic [CSR_IDX_W-1:0] index;
   logic [CSR_DAT_W-1:0] data;
   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

// ----- rtl/rgbc_datapath.sv -----
// ----------------------------------------------------------------------------
// rgbc_datapath
// line stores, window, counters, multiply-accumulate, divider, output word
// ----------------------------------------------------------------------------
module rgbc_datapath
   import rgbc_pkg::*;
#(
   parameter int MAX_WIDTH = 1024
) (
   input  logic                 clock,
   input  logic                 reset,
   input  cmd_type              cmd,
   output sts_type              sts,
   input  logic                 req_command,
   input  logic [7:0]           req_red_in,
   input  logic [7:0]           req_green_in,
   input  logic [7:0]           req_blue_in,
   input  logic [7:0]           req_alpha_in,
   input  logic                 csr_we,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CSR_DAT_W-1:0] csr_data,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic [7:0]           rsp_red_out,
   output logic [7:0]           rsp_green_out,
   output logic [7:0]           rsp_blue_out,
   output logic [7:0]           rsp_alpha_out,
   output logic                 rsp_frame_end
);

   localparam int AW = $clog2(MAX_WIDTH);
   localparam int CW = $clog2(MAX_WIDTH + 1);
   localparam logic [ROW_W-1:0] ROW_SAT = '1;

   // configuration
   logic [10:0]    width_ff;
   logic [12:0]    height_ff;
   logic [23:0]    ktop_ff, kmid_ff, kbot_ff;
   logic [11:0]    div_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= 11'd1024;
         height_ff <= 13'd1;
         ktop_ff   <= 24'd0;
         kmid_ff   <= 24'd256;
         kbot_ff   <= 24'd0;
         div_ff    <= 12'd1;
      end else if (csr_we) begin
         unique case (csr_index)
            REG_WIDTH:   width_ff  <= csr_data[10:0];
            REG_HEIGHT:  height_ff <= csr_data[12:0];
            REG_KTOP:    ktop_ff   <= csr_data;
            REG_KMID:    kmid_ff   <= csr_data;
            REG_KBOT:    kbot_ff   <= csr_data;
            REG_DIVISOR: div_ff    <= csr_data[11:0];
            default: ;
         endcase
      end
   end

   logic [CW-1:0]    eff_w;
   logic [ROW_W-1:0] eff_h;

   always_comb begin
      if (width_ff == '0)
         eff_w = CW'(1);
      else if (32'(width_ff) > MAX_WIDTH)
         eff_w = CW'(MAX_WIDTH);
      else
         eff_w = CW'(width_ff);
      if (height_ff == '0)
         eff_h = ROW_W'(1);
      else if (32'(height_ff) > MAX_ROWS)
         eff_h = ROW_W'(MAX_ROWS);
      else
         eff_h = height_ff;
   end

   // input word
   logic [31:0] pix_ff;

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         if (req_command == CMD_DRAIN)
            pix_ff <= 32'd0;
         else
            pix_ff <= {req_alpha_in, req_blue_in, req_green_in, req_red_in};
      end
   end

   // counters
   logic [CW-1:0]    in_col_ff, in_col_in, out_col_ff, out_col_in;
   logic [ROW_W-1:0] in_row_ff, in_row_in, out_row_ff, out_row_in;
   logic [CW-1:0]    a_ic, a_oc, s_ic;
   logic [ROW_W-1:0] a_ir, a_or, s_ir;
   logic             last;

   // size changes between items land here before the item is handled
   always_comb begin
      a_ic = in_col_ff;
      a_ir = in_row_ff;
      a_or = out_row_ff;
      a_oc = out_col_ff;
      if (a_or >= eff_h) begin
         a_ic = '0;
         a_ir = '0;
         a_or = '0;
         a_oc = '0;
      end
      if (a_ic >= eff_w) begin
         a_ic = '0;
         if (a_ir != ROW_SAT) a_ir = a_ir + ROW_W'(1);
      end
      if (a_oc >= eff_w) begin
         a_oc = '0;
         a_or = a_or + ROW_W'(1);
         if (a_or >= eff_h) begin
            a_ic = '0;
            a_ir = '0;
            a_or = '0;
         end
      end
   end

   always_comb begin
      s_ic = in_col_ff + CW'(1);
      s_ir = in_row_ff;
      if (s_ic >= eff_w) begin
         s_ic = '0;
         if (s_ir != ROW_SAT) s_ir = s_ir + ROW_W'(1);
      end
   end

   assign last = ({1'b0, out_row_ff} + (ROW_W+1)'(1) >= {1'b0, eff_h}) &&
                 ({1'b0, out_col_ff} + (CW+1)'(1) >= {1'b0, eff_w});

   logic [CW-1:0]    adv_col;
   logic [ROW_W-1:0] adv_row;

   always_comb begin
      adv_col = out_col_ff + CW'(1);
      adv_row = out_row_ff;
      if (adv_col >= eff_w) begin
         adv_col = '0;
         adv_row = out_row_ff + ROW_W'(1);
      end
   end

   always_comb begin
      in_col_in  = in_col_ff;
      in_row_in  = in_row_ff;
      out_col_in = out_col_ff;
      out_row_in = out_row_ff;
      if (cmd.adjust) begin
         in_col_in  = a_ic;
         in_row_in  = a_ir;
         out_col_in = a_oc;
         out_row_in = a_or;
      end else begin
         if (cmd.shift) begin
            in_col_in = s_ic;
            in_row_in = s_ir;
         end else if (cmd.load_rsp) begin
            if (last) begin
               in_col_in  = '0;
               in_row_in  = '0;
               out_col_in = '0;
               out_row_in = '0;
            end else begin
               out_col_in = adv_col;
               out_row_in = adv_row;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_col_ff  <= '0;
         in_row_ff  <= '0;
         out_col_ff <= '0;
         out_row_ff <= '0;
      end else begin
         in_col_ff  <= in_col_in;
         in_row_ff  <= in_row_in;
         out_col_ff <= out_col_in;
         out_row_ff <= out_row_in;
      end
   end

   // line stores
   logic [31:0] older_mem [MAX_WIDTH];
   logic [31:0] newer_mem [MAX_WIDTH];
   logic [31:0] older_q, newer_q;

   always_ff @(posedge clock) begin
      if (cmd.adjust) begin
         older_q <= older_mem[a_ic[AW-1:0]];
         newer_q <= newer_mem[a_ic[AW-1:0]];
      end
      if (cmd.shift) begin
         older_mem[in_col_ff[AW-1:0]] <= newer_q;
         newer_mem[in_col_ff[AW-1:0]] <= pix_ff;
      end
   end

   // window
   logic [31:0] win_ff [3][3];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int r = 0; r < 3; r++)
            for (int c = 0; c < 3; c++)
               win_ff[r][c] <= 32'd0;
      end else if (cmd.shift) begin
         for (int r = 0; r < 3; r++) begin
            win_ff[r][0] <= win_ff[r][1];
            win_ff[r][1] <= win_ff[r][2];
         end
         win_ff[0][2] <= older_q;
         win_ff[1][2] <= newer_q;
         win_ff[2][2] <= pix_ff;
      end
   end

   // tap selection with clamp-to-edge
   logic [1:0]  ri, ci;
   logic [31:0] tap_pix;
   logic [23:0] krow;
   logic signed [7:0] wgt;

   always_comb begin
      unique case (cmd.tap_row)
         2'd0:    ri = (out_row_ff == '0) ? 2'd1 : 2'd0;
         2'd2:    ri = ({1'b0, out_row_ff} + (ROW_W+1)'(1) >= {1'b0, eff_h}) ? 2'd1 : 2'd2;
         default: ri = 2'd1;
      endcase
      unique case (cmd.tap_col)
         2'd0:    ci = (out_col_ff == '0) ? 2'd1 : 2'd0;
         2'd2:    ci = ({1'b0, out_col_ff} + (CW+1)'(1) >= {1'b0, eff_w}) ? 2'd1 : 2'd2;
         default: ci = 2'd1;
      endcase
      case (cmd.tap_row)
         2'd0:    krow = ktop_ff;
         2'd2:    krow = kbot_ff;
         default: krow = kmid_ff;
      endcase
   end

   assign tap_pix = win_ff[ri][ci];
   assign wgt     = $signed(krow[8*cmd.tap_col +: 8]);

   // multiply-accumulate, three channels side by side
   logic signed [SUM_W-1:0] sum_ff [3];
   logic signed [16:0]      prod [3];

   always_comb begin
      for (int ch = 0; ch < 3; ch++)
         prod[ch] = $signed({1'b0, tap_pix[8*ch +: 8]}) * wgt;
   end

   always_ff @(posedge clock) begin
      if (cmd.mac_en) begin
         for (int ch = 0; ch < 3; ch++) begin
            if (cmd.mac_clear)
               sum_ff[ch] <= SUM_W'(prod[ch]);
            else
               sum_ff[ch] <= sum_ff[ch] + SUM_W'(prod[ch]);
         end
      end
   end

   // restoring divider: floor((2a+d)/(2d)), quotient shifts into num
   logic signed [11:0] sdiv;
   logic [11:0]        dmag;
   logic [DEN_W-1:0]   den;
   logic [NUM_W-1:0]   num_ff [3];
   logic [DEN_W:0]     rem_ff [3];
   logic               neg_ff [3];
   logic [SUM_W-1:0]   amag [3];
   logic [DEN_W:0]     trial [3];

   assign sdiv = $signed(div_ff);
   assign dmag = sdiv[11] ? 12'(-sdiv) : div_ff;
   assign den  = {dmag, 1'b0};

   always_comb begin
      for (int ch = 0; ch < 3; ch++) begin
         amag[ch]  = sum_ff[ch][SUM_W-1] ? SUM_W'(-sum_ff[ch]) : SUM_W'(sum_ff[ch]);
         trial[ch] = {rem_ff[ch][DEN_W-1:0], num_ff[ch][NUM_W-1]};
      end
   end

   always_ff @(posedge clock) begin
      for (int ch = 0; ch < 3; ch++) begin
         if (cmd.div_load) begin
            num_ff[ch] <= NUM_W'({amag[ch], 1'b0}) + NUM_W'(dmag);
            rem_ff[ch] <= '0;
            neg_ff[ch] <= sum_ff[ch][SUM_W-1] ^ sdiv[11];
         end else if (cmd.div_step) begin
            if (trial[ch] >= {1'b0, den}) begin
               rem_ff[ch] <= trial[ch] - {1'b0, den};
               num_ff[ch] <= {num_ff[ch][NUM_W-2:0], 1'b1};
            end else begin
               rem_ff[ch] <= trial[ch];
               num_ff[ch] <= {num_ff[ch][NUM_W-2:0], 1'b0};
            end
         end
      end
   end

   logic [7:0] chan_res [3];

   always_comb begin
      for (int ch = 0; ch < 3; ch++) begin
         if (div_ff == '0) begin
            if (sum_ff[ch][SUM_W-1])
               chan_res[ch] = 8'd0;
            else if (sum_ff[ch] > SUM_W'(255))
               chan_res[ch] = 8'd255;
            else
               chan_res[ch] = sum_ff[ch][7:0];
         end else if (neg_ff[ch]) begin
            chan_res[ch] = 8'd0;
         end else if (num_ff[ch] > NUM_W'(255)) begin
            chan_res[ch] = 8'd255;
         end else begin
            chan_res[ch] = num_ff[ch][7:0];
         end
      end
   end

   // output word
   logic       rsp_valid_ff;
   logic [7:0] red_ff, green_ff, blue_ff, alpha_ff;
   logic       fend_ff;

   always_ff @(posedge clock) begin
      if (reset)
         rsp_valid_ff <= 1'b0;
      else if (cmd.load_rsp)
         rsp_valid_ff <= 1'b1;
      else if (rsp_ready)
         rsp_valid_ff <= 1'b0;
   end

   always_ff @(posedge clock) begin
      if (cmd.load_rsp) begin
         red_ff   <= chan_res[0];
         green_ff <= chan_res[1];
         blue_ff  <= chan_res[2];
         alpha_ff <= win_ff[1][1][31:24];
         fend_ff  <= last;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_red_out   = red_ff;
   assign rsp_green_out = green_ff;
   assign rsp_blue_out  = blue_ff;
   assign rsp_alpha_out = alpha_ff;
   assign rsp_frame_end = fend_ff;

   assign sts.primed   = (in_row_ff >= ROW_W'(2)) ||
                         ((in_row_ff == ROW_W'(1)) && (in_col_ff != '0));
   assign sts.rsp_free = !rsp_valid_ff || rsp_ready;
   assign sts.last     = last;
   assign sts.origin   = (in_col_ff == '0) && (in_row_ff == '0) &&
                         (out_col_ff == '0) && (out_row_ff == '0);

endmodule

// ----- rtl/rgbc_ctrl.sv -----
// ----------------------------------------------------------------------------
// rgbc_ctrl
// sequencer for read, window shift, taps, divide and output
// ----------------------------------------------------------------------------
module rgbc_ctrl
   import rgbc_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  sts_type sts,
   output cmd_type cmd
);

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_READ  = 3'd1;
   localparam logic [2:0] S_SHIFT = 3'd2;
   localparam logic [2:0] S_MAC   = 3'd3;
   localparam logic [2:0] S_DIV   = 3'd4;
   localparam logic [2:0] S_OUT   = 3'd5;

   logic [2:0] state_ff, state_in;
   logic [1:0] row_ff, row_in, col_ff, col_in;
   logic [4:0] step_ff, step_in;

   always_comb begin
      state_in  = state_ff;
      row_in    = row_ff;
      col_in    = col_ff;
      step_in   = step_ff;
      req_ready = 1'b0;
      cmd       = '0;
      cmd.tap_row = row_ff;
      cmd.tap_col = col_ff;
      unique case (state_ff)
         S_IDLE: begin
            req_ready   = 1'b1;
            cmd.capture = req_valid;
            if (req_valid) state_in = S_READ;
         end
         S_READ: begin
            cmd.adjust = 1'b1;
            state_in   = S_SHIFT;
         end
         S_SHIFT: begin
            cmd.shift = 1'b1;
            row_in    = 2'd0;
            col_in    = 2'd0;
            state_in  = sts.primed ? S_MAC : S_IDLE;
         end
         S_MAC: begin
            cmd.mac_en    = 1'b1;
            cmd.mac_clear = (row_ff == 2'd0) && (col_ff == 2'd0);
            if (col_ff == 2'd2) begin
               col_in = 2'd0;
               if (row_ff == 2'd2) begin
                  row_in   = 2'd0;
                  step_in  = 5'd0;
                  state_in = S_DIV;
               end else begin
                  row_in = row_ff + 2'd1;
               end
            end else begin
               col_in = col_ff + 2'd1;
            end
         end
         S_DIV: begin
            cmd.div_load = (step_ff == 5'd0);
            cmd.div_step = (step_ff != 5'd0);
            if (step_ff == DIV_STEPS)
               state_in = S_OUT;
            else
               step_in = step_ff + 5'd1;
         end
         S_OUT: begin
            // hold until the output word is free
            cmd.load_rsp = sts.rsp_free;
            if (sts.rsp_free) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         row_ff   <= 2'd0;
         col_ff   <= 2'd0;
         step_ff  <= 5'd0;
      end else begin
         state_ff <= state_in;
         row_ff   <= row_in;
         col_ff   <= col_in;
         step_ff  <= step_in;
      end
   end

endmodule

// ----- rtl/rgb_convolution_3x3.sv -----
// ----------------------------------------------------------------------------
// rgb_convolution_3x3
// streaming 3x3 rgb convolution with clamp-to-edge borders
// ----------------------------------------------------------------------------
// One word is taken at a time. A word that produces no result (the first
// image_width+1 of a frame) passes through accept, line store read and
// window shift. A word that produces a result goes through those, then
// the nine taps on the shared multiply-accumulate (one tap per cycle, three
// channels side by side), the restoring divider (load plus 22 quotient bits)
// and the load of the output word, which waits only while the previous
// result is not taken. The output word is a register of its own, so a new
// word is accepted while a result waits. Results lag input by image_width+1
// words; send image_width+1 drain words after a frame.
// ----------------------------------------------------------------------------
`include "rgb_convolution_3x3_macros.svh"

module rgb_convolution_3x3
   import rgbc_pkg::*;
#(
   parameter int MAX_WIDTH = 1024
) (
   input logic      clock,
   input logic      reset,
   rgbc_req_if.sink   req_chan,
   rgbc_rsp_if.source rsp_chan,
   rgbc_csr_if.sink   csr_chan
);

   cmd_type cmd;
   sts_type sts;
   logic    ctrl_ready;

   assign req_chan.ready = ctrl_ready;
   assign csr_chan.ready = 1'b1;

   rgbc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (ctrl_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   rgbc_datapath #(
      .MAX_WIDTH (MAX_WIDTH)
   ) u_datapath (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .sts           (sts),
      .req_command   (req_chan.command),
      .req_red_in    (req_chan.red_in),
      .req_green_in  (req_chan.green_in),
      .req_blue_in   (req_chan.blue_in),
      .req_alpha_in  (req_chan.alpha_in),
      .csr_we        (csr_chan.valid),
      .csr_index     (csr_chan.index),
      .csr_data      (csr_chan.data),
      .rsp_valid     (rsp_chan.valid),
      .rsp_ready     (rsp_chan.ready),
      .rsp_red_out   (rsp_chan.red_out),
      .rsp_green_out (rsp_chan.green_out),
      .rsp_blue_out  (rsp_chan.blue_out),
      .rsp_alpha_out (rsp_chan.alpha_out),
      .rsp_frame_end (rsp_chan.frame_end)
   );

   // one word in flight
   `RGBC_ASSERT_NXT(a_one_word, clock, reset, req_chan.valid && req_chan.ready, !req_chan.ready)
   // last result of a frame returns every counter to the start
   `RGBC_ASSERT_NXT(a_frame_wrap, clock, reset, cmd.load_rsp && sts.last, sts.origin)
   // a result is only loaded when the output word is free
   `RGBC_ASSERT_IMP(a_no_overrun, clock, reset, cmd.load_rsp, !rsp_chan.valid || rsp_chan.ready)

endmodule

// ----- test/rgb_convolution_3x3_tb.sv -----
// ----------------------------------------------------------------------------
// rgb_convolution_3x3_tb
// drives whole frames of rgba pixels plus drain words through the 3x3 filter
// under many kernel, divisor and frame-size settings; every filtered word is
// compared field by field against a software line-store and window model,
// or against fixed expected values for the typed directed words
module rgb_convolution_3x3_tb;
   import rgbc_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int LINE_MAX   = 1024;
   localparam int CYCLE_LIMIT = 3000000;
   localparam int HOLD_CYCLES = 400;
   localparam int ITEM_GOAL  = 1700;

   typedef struct packed {
      logic       command;
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
      logic [7:0] alpha;
   } pixel_word_type;

   typedef struct packed {
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
      logic [7:0] alpha;
      logic       frame_end;
   } filtered_word_type;

   typedef struct {
      pixel_word_type    word;
      bit                typed;
      filtered_word_type want;
   } stim_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   rgbc_req_if req_chan ();
   rgbc_rsp_if rsp_chan ();
   rgbc_csr_if csr_chan ();

   rgb_convolution_3x3 u_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan.sink),
      .rsp_chan (rsp_chan.source),
      .csr_chan (csr_chan.sink)
   );

   // filter model state
   logic [10:0] cfg_width;
   logic [12:0] cfg_height;
   logic [23:0] cfg_kernel [3];
   logic [11:0] cfg_divisor;
   logic [31:0] older_line [LINE_MAX];
   logic [31:0] newer_line [LINE_MAX];
   logic [31:0] window [3][3];
   int unsigned in_col, in_row, out_col, out_row;

   filtered_word_type filtered_q [$];
   int  errors = 0;
   int  items_sent = 0;
   int  cycles = 0;
   bit  no_idle = 1'b0;
   bit  hold_request = 1'b0;
   int  hold_left = 0;

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("FAIL rgb_convolution_3x3");
         $finish;
      end
   end

   task automatic report(input string what, input int got, input int want);
      errors++;
      $display("mismatch %s: got %0d want %0d at cycle %0d", what, got, want, cycles);
   endtask

   function automatic void clear_position();
      in_col = 0; in_row = 0; out_col = 0; out_row = 0;
   endfunction

   function automatic void reset_model();
      cfg_width = 11'd1024;
      cfg_height = 13'd1;
      cfg_kernel[0] = 24'd0;
      cfg_kernel[1] = 24'd256;
      cfg_kernel[2] = 24'd0;
      cfg_divisor = 12'd1;
      for (int i = 0; i < 3; i++)
         for (int j = 0; j < 3; j++) window[i][j] = '0;
      clear_position();
   endfunction

   function automatic logic [7:0] round_clamp(input int sum, input int div);
      int v, a, d, q;
      if (div == 0) begin
         v = sum;
      end else begin
         a = sum < 0 ? -sum : sum;
         d = div < 0 ? -div : div;
         q = (2 * a + d) / (2 * d);
         v = ((sum < 0) != (div < 0)) ? -q : q;
      end
      if (v < 0) v = 0;
      if (v > 255) v = 255;
      return v[7:0];
   endfunction

   // advances the model by one accepted word; returns 1 when a result is due
   function automatic bit filter_step(input pixel_word_type w, output filtered_word_type o);
      int unsigned eff_w, eff_h;
      int div, sum;
      logic [31:0] pix, p;
      bit primed, last;
      int rsel [3];
      int csel [3];
      eff_w = cfg_width < 1 ? 1 : (cfg_width > LINE_MAX ? LINE_MAX : cfg_width);
      eff_h = cfg_height < 1 ? 1 : (cfg_height > MAX_ROWS ? MAX_ROWS : cfg_height);
      div = $signed(cfg_divisor);
      o = '0;
      if (out_row >= eff_h) clear_position();
      if (in_col >= eff_w) begin
         in_col = 0;
         if (in_row < 8191) in_row++;
      end
      if (out_col >= eff_w) begin
         out_col = 0;
         out_row++;
         if (out_row >= eff_h) clear_position();
      end
      pix = (w.command == CMD_PIXEL) ? {w.alpha, w.blue, w.green, w.red} : 32'd0;
      for (int r = 0; r < 3; r++) begin
         window[r][0] = window[r][1];
         window[r][1] = window[r][2];
      end
      window[0][2] = older_line[in_col];
      window[1][2] = newer_line[in_col];
      window[2][2] = pix;
      older_line[in_col] = newer_line[in_col];
      newer_line[in_col] = pix;
      primed = in_row >= 2 || (in_row == 1 && in_col >= 1);
      in_col++;
      if (in_col >= eff_w) begin
         in_col = 0;
         if (in_row < 8191) in_row++;
      end
      if (!primed) return 1'b0;
      // clamp-to-edge: outside rows and columns repeat the centre
      rsel[0] = out_row == 0 ? 1 : 0;
      rsel[1] = 1;
      rsel[2] = out_row + 1 >= eff_h ? 1 : 2;
      csel[0] = out_col == 0 ? 1 : 0;
      csel[1] = 1;
      csel[2] = out_col + 1 >= eff_w ? 1 : 2;
      for (int ch = 0; ch < 3; ch++) begin
         sum = 0;
         for (int r = 0; r < 3; r++)
            for (int c = 0; c < 3; c++) begin
               p = window[rsel[r]][csel[c]];
               sum += int'(p[8*ch +: 8]) * int'($signed(cfg_kernel[r][8*c +: 8]));
            end
         case (ch)
            0: o.red = round_clamp(sum, div);
            1: o.green = round_clamp(sum, div);
            default: o.blue = round_clamp(sum, div);
         endcase
      end
      o.alpha = window[1][1][31:24];
      last = out_row + 1 >= eff_h && out_col + 1 >= eff_w;
      o.frame_end = last;
      if (last) begin
         clear_position();
      end else begin
         out_col++;
         if (out_col >= eff_w) begin
            out_col = 0;
            out_row++;
         end
      end
      return 1'b1;
   endfunction

   // valid stays up between back-to-back writes; setup drops it after the last
   task automatic csr_write(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DAT_W-1:0] val);
      csr_chan.valid <= 1'b1;
      csr_chan.index <= idx;
      csr_chan.data <= val;
      do @(posedge clock); while (!csr_chan.ready);
      case (idx)
         REG_WIDTH:   cfg_width = val[10:0];
         REG_HEIGHT:  cfg_height = val[12:0];
         REG_KTOP:    cfg_kernel[0] = val;
         REG_KMID:    cfg_kernel[1] = val;
         REG_KBOT:    cfg_kernel[2] = val;
         default:     cfg_divisor = val[11:0];
      endcase
   endtask

   // sender pause: nothing is written until all results are back and settled
   task automatic wait_idle();
      req_chan.valid <= 1'b0;
      while (filtered_q.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);
   endtask

   task automatic setup(input int w, input int h, input logic [23:0] kt,
                        input logic [23:0] km, input logic [23:0] kb, input int div);
      wait_idle();
      csr_write(REG_WIDTH, {13'($urandom_range(0, 8191)), 11'(w)});
      csr_write(REG_HEIGHT, {11'($urandom_range(0, 2047)), 13'(h)});
      csr_write(REG_KTOP, kt);
      csr_write(REG_KMID, km);
      csr_write(REG_KBOT, kb);
      csr_write(REG_DIVISOR, {12'($urandom_range(0, 4095)), 12'(div)});
      csr_chan.valid <= 1'b0;
   endtask

   task automatic send_word(input pixel_word_type w, input bit typed,
                            input filtered_word_type want);
      filtered_word_type got;
      if (!no_idle && $urandom_range(0, 99) < 20) begin
         req_chan.valid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
      req_chan.valid <= 1'b1;
      req_chan.command <= w.command;
      req_chan.red_in <= w.red;
      req_chan.green_in <= w.green;
      req_chan.blue_in <= w.blue;
      req_chan.alpha_in <= w.alpha;
      do @(posedge clock); while (!req_chan.ready);
      items_sent++;
      if (filter_step(w, got)) filtered_q = {filtered_q, typed ? want : got};
   endtask

   function automatic logic [7:0] rand_channel();
      case ($urandom_range(0, 7))
         0: return 8'h00;
         1: return 8'hff;
         default: return 8'($urandom);
      endcase
   endfunction

   function automatic logic [23:0] rand_kernel();
      case ($urandom_range(0, 5))
         0: return {3{8'h7f}};
         1: return {3{8'h80}};
         2: return {8'($urandom_range(0, 3)), 8'($urandom_range(0, 8)), 8'($urandom_range(0, 3))};
         default: return 24'($urandom);
      endcase
   endfunction

   // one whole frame; noise swaps the command of some words
   task automatic send_frame(input int w, input int h, input bit noise);
      pixel_word_type pw;
      filtered_word_type none;
      none = '0;
      for (int i = 0; i < w * h + w + 1; i++) begin
         pw.command = (i < w * h) ? CMD_PIXEL : CMD_DRAIN;
         if (noise && $urandom_range(0, 9) == 0) pw.command = ~pw.command;
         pw.red = rand_channel();
         pw.green = rand_channel();
         pw.blue = rand_channel();
         pw.alpha = rand_channel();
         send_word(pw, 1'b0, none);
      end
   endtask

   // receiver side, with its own long hold-off counter
   always @(posedge clock) begin
      if (reset) begin
         rsp_chan.ready <= 1'b0;
      end else begin
         if (rsp_chan.valid && rsp_chan.ready) begin
            if (filtered_q.size() == 0) begin
               report("unexpected word", 0, 0);
            end else begin
               filtered_word_type e;
               e = filtered_q.pop_front();
               if (rsp_chan.red_out !== e.red) report("red_out", rsp_chan.red_out, e.red);
               if (rsp_chan.green_out !== e.green)
                  report("green_out", rsp_chan.green_out, e.green);
               if (rsp_chan.blue_out !== e.blue) report("blue_out", rsp_chan.blue_out, e.blue);
               if (rsp_chan.alpha_out !== e.alpha)
                  report("alpha_out", rsp_chan.alpha_out, e.alpha);
               if (rsp_chan.frame_end !== e.frame_end)
                  report("frame_end", rsp_chan.frame_end, e.frame_end);
            end
         end
         if (hold_request && hold_left == 0) begin
            hold_left = HOLD_CYCLES;
            hold_request = 1'b0;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_chan.ready <= 1'b0;
         end else begin
            rsp_chan.ready <= no_idle ? 1'b1 : ($urandom_range(0, 99) >= 20);
         end
      end
   end

   stim_row_type directed [7];

   initial begin
      int w, h, wait_cycles;
      req_chan.valid = 1'b0;
      req_chan.command = CMD_PIXEL;
      req_chan.red_in = '0;
      req_chan.green_in = '0;
      req_chan.blue_in = '0;
      req_chan.alpha_in = '0;
      csr_chan.valid = 1'b0;
      csr_chan.index = REG_WIDTH;
      csr_chan.data = '0;
      reset_model();
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // 2x2 frame under the identity kernel: each word comes back as sent
      directed[0] = '{'{CMD_PIXEL, 8'h00, 8'h00, 8'h00, 8'h00}, 1'b0, '0};
      directed[1] = '{'{CMD_PIXEL, 8'hff, 8'hff, 8'hff, 8'hff}, 1'b0, '0};
      directed[2] = '{'{CMD_PIXEL, 8'h80, 8'h7f, 8'h01, 8'hfe}, 1'b0, '0};
      directed[3] = '{'{CMD_PIXEL, 8'h55, 8'haa, 8'h0f, 8'hf0}, 1'b1,
                      '{8'h00, 8'h00, 8'h00, 8'h00, 1'b0}};
      directed[4] = '{'{CMD_DRAIN, 8'h00, 8'h00, 8'h00, 8'h00}, 1'b1,
                      '{8'hff, 8'hff, 8'hff, 8'hff, 1'b0}};
      directed[5] = '{'{CMD_DRAIN, 8'hff, 8'hff, 8'hff, 8'hff}, 1'b1,
                      '{8'h80, 8'h7f, 8'h01, 8'hfe, 1'b0}};
      directed[6] = '{'{CMD_DRAIN, 8'h00, 8'h00, 8'h00, 8'h00}, 1'b1,
                      '{8'h55, 8'haa, 8'h0f, 8'hf0, 1'b1}};
      setup(2, 2, 24'd0, 24'd256, 24'd0, 1);
      foreach (directed[i]) send_word(directed[i].word, directed[i].typed, directed[i].want);
      // same words, extreme weights, with divisors -2048 (the most negative), 0 and 2047
      setup(2, 2, {3{8'h7f}}, {3{8'h80}}, {3{8'h7f}}, -2048);
      foreach (directed[i]) send_word(directed[i].word, 1'b0, '0);
      setup(2, 2, {3{8'h80}}, {3{8'h80}}, {3{8'h80}}, 0);
      foreach (directed[i]) send_word(directed[i].word, 1'b0, '0);
      setup(2, 2, {3{8'h7f}}, {3{8'h7f}}, {3{8'h7f}}, 2047);
      foreach (directed[i]) send_word(directed[i].word, 1'b0, '0);

      // out-of-range sizes clamp: width 0 and height 0 act as 1
      setup(0, 0, 24'd0, 24'h000300, 24'd0, 3);
      send_frame(1, 1, 1'b0);

      for (int f = 0; items_sent < ITEM_GOAL; f++) begin
         if ($urandom_range(0, 19) == 0) begin
            w = $urandom_range(40, 200);
            h = 1;
         end else begin
            w = $urandom_range(1, 8);
            h = $urandom_range(1, 6);
         end
         case ($urandom_range(0, 3))
            0: setup(w, h, rand_kernel(), rand_kernel(), rand_kernel(), 0);
            1: setup(w, h, rand_kernel(), rand_kernel(), rand_kernel(),
                     $urandom_range(0, 4095) - 2048);
            default: setup(w, h, rand_kernel(), rand_kernel(), rand_kernel(),
                           $urandom_range(1, 40));
         endcase
         no_idle = (f >= 10 && f < 16);
         if (f == 5) hold_request = 1'b1;
         send_frame(w, h, $urandom_range(0, 4) == 0);
         // a second frame with no write in between
         if ($urandom_range(0, 3) == 0) send_frame(w, h, 1'b0);
      end
      no_idle = 1'b0;

      req_chan.valid <= 1'b0;
      wait_cycles = 0;
      while (filtered_q.size() != 0 && wait_cycles < 200000) begin
         @(posedge clock);
         wait_cycles++;
      end
      repeat (60) @(posedge clock);
      if (errors == 0 && filtered_q.size() == 0) begin
         $display("PASS rgb_convolution_3x3");
      end else begin
         $display("FAIL rgb_convolution_3x3");
      end
      $finish;
   end

endmodule
